### hw/rtl/pfpt_pkg.sv
// Shared types, constants and the arctangent table for the planar pose transform.
package pfpt_pkg;

    // Field widths
    localparam int POS_W          = 32;
    localparam int ANG_W          = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // Datapath widths: guard bits, rotator word, gain split, product, rounded result
    localparam int GUARD  = 6;
    localparam int XW     = 42;
    localparam int LOW_W  = 21;
    localparam int HIGH_W = XW - LOW_W;
    localparam int FW     = 24;
    localparam int PW     = 68;
    localparam int RSHIFT = 29;
    localparam int RW     = 37;

    // Gain correction in Q23, and unity for pass-through items
    localparam logic [FW-1:0] GAIN_Q23  = 24'd5094007;
    localparam logic [FW-1:0] UNITY_Q23 = 24'd8388608;

    // Transform commands
    typedef enum logic [1:0] {
        CMD_TO_CHILD  = 2'd0,
        CMD_TO_PARENT = 2'd1,
        CMD_INVERT    = 2'd2,
        CMD_PASS      = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_X     = 2'd0,
        REG_FRAME_Y     = 2'd1,
        REG_FRAME_THETA = 2'd2
    } reg_idx_t;

    // Sideband that rides along the rotator chain
    typedef struct packed {
        cmd_t             cmd;
        logic [ANG_W-1:0] heading;
    } tag_t;

    // One finished result item
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ANG_W-1:0] heading;
        logic             sat;
    } res_t;

    // atan(2^-i) as 32-bit fractions of a turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Table entry rounded half-up onto an ab-bit angle grid, in grid units
    function automatic logic [31:0] atan_step(input int idx, input int ab);
        logic [32:0] s;
        s = {1'b0, ATAN_TURNS[idx]} + (33'd1 << (31 - ab));
        return 32'(s >> (32 - ab));
    endfunction

endpackage

### hw/rtl/planar_frame_pose_transform.sv
// Top level: frame registers, CORDIC cell chain, gain stages, offset/clamp and output skid.
// Pipeline: the input stage register, one rotator cell per angle bit, two gain stages and
// the output register.
// Throughput: one item per cycle; the chain stalls only while the output skid is full.
// Reset (aresetn low, synchronous) clears the frame registers to zero and empties
// every pipeline stage and the output/skid registers.
module planar_frame_pose_transform #(
    parameter int ANGLE_BITS = pfpt_pkg::ANGLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // in_x[31:0], in_y[63:32], in_heading[79:64]
    input  logic [1:0]  s_tuser,  // cmd[1:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // out_x[31:0], out_y[63:32], out_heading[79:64]
    output logic [0:0]  m_tuser   // saturated[0]
);

    localparam int ZW  = ANGLE_BITS + 2;
    localparam int EW  = pfpt_pkg::RW + 1;
    localparam int PW_ = pfpt_pkg::POS_W;

    // Frame registers
    logic signed [PW_-1:0]            frame_x_reg;
    logic signed [PW_-1:0]            frame_y_reg;
    logic [pfpt_pkg::ANG_W-1:0]       frame_theta_reg;

    logic                             en;

    // Chain taps: index 0 is the input stage, ANGLE_BITS the last cell
    logic                             cv [ANGLE_BITS+1];
    logic signed [pfpt_pkg::XW-1:0]   cx [ANGLE_BITS+1];
    logic signed [pfpt_pkg::XW-1:0]   cy [ANGLE_BITS+1];
    logic signed [ZW-1:0]             cz [ANGLE_BITS+1];
    pfpt_pkg::tag_t                   ct [ANGLE_BITS+1];

    logic                             g_valid;
    logic signed [pfpt_pkg::RW-1:0]   g_x;
    logic signed [pfpt_pkg::RW-1:0]   g_y;
    pfpt_pkg::tag_t                   g_tag;

    logic signed [EW-1:0]             ex;
    logic signed [EW-1:0]             ey;
    logic                             ovf_x;
    logic                             ovf_y;
    pfpt_pkg::res_t                   res;

    logic                             out_valid_reg, out_valid_next;
    pfpt_pkg::res_t                   out_reg, out_next;
    logic                             skid_valid_reg, skid_valid_next;
    pfpt_pkg::res_t                   skid_reg, skid_next;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_x_reg     <= '0;
            frame_y_reg     <= '0;
            frame_theta_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pfpt_pkg::REG_FRAME_X:     frame_x_reg     <= cfg_data;
                pfpt_pkg::REG_FRAME_Y:     frame_y_reg     <= cfg_data;
                pfpt_pkg::REG_FRAME_THETA: frame_theta_reg <= cfg_data[pfpt_pkg::ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances while the skid slot is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    pfpt_prep #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_cmd      (pfpt_pkg::cmd_t'(s_tuser)),
        .in_x        (s_tdata[31:0]),
        .in_y        (s_tdata[63:32]),
        .in_heading  (s_tdata[79:64]),
        .frame_x     (frame_x_reg),
        .frame_y     (frame_y_reg),
        .frame_theta (frame_theta_reg),
        .out_valid   (cv[0]),
        .out_x       (cx[0]),
        .out_y       (cy[0]),
        .out_z       (cz[0]),
        .out_tag     (ct[0])
    );

    // Row of micro-rotation cells
    for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_cell
        pfpt_cell #(
            .ANGLE_BITS (ANGLE_BITS),
            .STAGE      (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .in_x      (cx[i]),
            .in_y      (cy[i]),
            .in_z      (cz[i]),
            .in_tag    (ct[i]),
            .out_valid (cv[i+1]),
            .out_x     (cx[i+1]),
            .out_y     (cy[i+1]),
            .out_z     (cz[i+1]),
            .out_tag   (ct[i+1])
        );
    end

    pfpt_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cv[ANGLE_BITS]),
        .in_x      (cx[ANGLE_BITS]),
        .in_y      (cy[ANGLE_BITS]),
        .in_tag    (ct[ANGLE_BITS]),
        .out_valid (g_valid),
        .out_x     (g_x),
        .out_y     (g_y),
        .out_tag   (g_tag)
    );

    // Offset add or negate, then clamp to 32 bits
    always_comb begin
        case (g_tag.cmd)
            pfpt_pkg::CMD_TO_PARENT: begin
                ex = EW'(g_x) + EW'(frame_x_reg);
                ey = EW'(g_y) + EW'(frame_y_reg);
            end
            pfpt_pkg::CMD_INVERT: begin
                ex = -EW'(g_x);
                ey = -EW'(g_y);
            end
            default: begin
                ex = EW'(g_x);
                ey = EW'(g_y);
            end
        endcase
    end

    assign ovf_x = !((&ex[EW-1:PW_-1]) || !(|ex[EW-1:PW_-1]));
    assign ovf_y = !((&ey[EW-1:PW_-1]) || !(|ey[EW-1:PW_-1]));

    always_comb begin
        res.x       = ovf_x ? (ex[EW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ex[PW_-1:0];
        res.y       = ovf_y ? (ey[EW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ey[PW_-1:0];
        res.heading = g_tag.heading;
        res.sat     = ovf_x || ovf_y;
    end

    // Output register with skid slot behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            if (g_valid) begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else begin
            out_valid_next = g_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.heading, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.sat;

endmodule

### hw/rtl/pfpt_prep.sv
// Input stage: picks offset and angle per command, folds quadrants, adds guard bits.
module pfpt_prep #(
    parameter int ANGLE_BITS = pfpt_pkg::ANGLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  pfpt_pkg::cmd_t                      in_cmd,
    input  logic signed [pfpt_pkg::POS_W-1:0]   in_x,
    input  logic signed [pfpt_pkg::POS_W-1:0]   in_y,
    input  logic [pfpt_pkg::ANG_W-1:0]          in_heading,
    input  logic signed [pfpt_pkg::POS_W-1:0]   frame_x,
    input  logic signed [pfpt_pkg::POS_W-1:0]   frame_y,
    input  logic [pfpt_pkg::ANG_W-1:0]          frame_theta,
    output logic                                out_valid,
    output logic signed [pfpt_pkg::XW-1:0]      out_x,
    output logic signed [pfpt_pkg::XW-1:0]      out_y,
    output logic signed [ANGLE_BITS+1:0]        out_z,
    output pfpt_pkg::tag_t                      out_tag
);

    localparam int ZW = ANGLE_BITS + 2;
    localparam int DW = pfpt_pkg::POS_W + 2;

    logic [pfpt_pkg::ANG_W-1:0]   rot_ang;
    logic [pfpt_pkg::ANG_W-1:0]   head_next;
    logic [31:0]                  ang32;
    logic [ANGLE_BITS-1:0]        zt;
    logic [ANGLE_BITS-1:0]        zf;
    logic                         fold;
    logic signed [DW-1:0]         ox;
    logic signed [DW-1:0]         oy;
    logic signed [DW-1:0]         xe;
    logic signed [DW-1:0]         ye;
    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;

    logic                         valid_reg;
    logic signed [pfpt_pkg::XW-1:0] x_reg, x_next;
    logic signed [pfpt_pkg::XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    pfpt_pkg::tag_t               tag_reg, tag_next;

    // Rotation angle and resulting heading per command
    always_comb begin
        rot_ang   = '0;
        head_next = in_heading;
        ox        = '0;
        oy        = '0;
        case (in_cmd)
            pfpt_pkg::CMD_TO_CHILD: begin
                rot_ang   = pfpt_pkg::ANG_W'(0) - frame_theta;
                head_next = in_heading - frame_theta;
                ox        = DW'(frame_x);
                oy        = DW'(frame_y);
            end
            pfpt_pkg::CMD_TO_PARENT: begin
                rot_ang   = frame_theta;
                head_next = in_heading + frame_theta;
            end
            pfpt_pkg::CMD_INVERT: begin
                rot_ang   = pfpt_pkg::ANG_W'(0) - in_heading;
                head_next = pfpt_pkg::ANG_W'(0) - in_heading;
            end
            default: begin
                rot_ang   = '0;
                head_next = in_heading;
            end
        endcase
    end

    // Truncate to the angle grid; quadrants 2 and 3 get a half turn and a negated vector
    assign ang32 = {rot_ang, 16'd0};
    assign zt    = ang32[31 -: ANGLE_BITS];
    assign fold  = zt[ANGLE_BITS-1] ^ zt[ANGLE_BITS-2];
    assign zf    = {zt[ANGLE_BITS-1] ^ fold, zt[ANGLE_BITS-2:0]};

    // Offset removal and fold in one add/subtract
    assign xe = DW'(in_x);
    assign ye = DW'(in_y);
    assign dx = fold ? (ox - xe) : (xe - ox);
    assign dy = fold ? (oy - ye) : (ye - oy);

    always_comb begin
        x_next       = pfpt_pkg::XW'(dx) <<< pfpt_pkg::GUARD;
        y_next       = pfpt_pkg::XW'(dy) <<< pfpt_pkg::GUARD;
        z_next       = ZW'($signed(zf));
        tag_next.cmd = in_cmd;
        tag_next.heading = head_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_tag   = tag_reg;

endmodule

### hw/rtl/pfpt_cell.sv
// One CORDIC micro-rotation cell of the rotator chain.
module pfpt_cell #(
    parameter int ANGLE_BITS = pfpt_pkg::ANGLE_BITS_DEF,
    parameter int STAGE      = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [pfpt_pkg::XW-1:0]  in_x,
    input  logic signed [pfpt_pkg::XW-1:0]  in_y,
    input  logic signed [ANGLE_BITS+1:0]    in_z,
    input  pfpt_pkg::tag_t                  in_tag,
    output logic                            out_valid,
    output logic signed [pfpt_pkg::XW-1:0]  out_x,
    output logic signed [pfpt_pkg::XW-1:0]  out_y,
    output logic signed [ANGLE_BITS+1:0]    out_z,
    output pfpt_pkg::tag_t                  out_tag
);

    localparam int ZW = ANGLE_BITS + 2;
    localparam logic signed [ZW-1:0] A_STEP = ZW'(pfpt_pkg::atan_step(STAGE, ANGLE_BITS));

    logic signed [pfpt_pkg::XW-1:0] xs;
    logic signed [pfpt_pkg::XW-1:0] ys;
    logic                           bypass;

    logic                           valid_reg;
    logic signed [pfpt_pkg::XW-1:0] x_reg, x_next;
    logic signed [pfpt_pkg::XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0]           z_reg, z_next;
    pfpt_pkg::tag_t                 tag_reg;

    // Floor shifts of the neighbor coordinate
    assign xs     = in_x >>> STAGE;
    assign ys     = in_y >>> STAGE;
    assign bypass = (in_tag.cmd == pfpt_pkg::CMD_PASS);

    // Rotate toward zero residual angle; pass-through items go untouched
    always_comb begin
        if (bypass) begin
            x_next = in_x;
            y_next = in_y;
            z_next = in_z;
        end else if (!in_z[ZW-1]) begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - A_STEP;
        end else begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + A_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_tag   = tag_reg;

endmodule

### hw/rtl/pfpt_gain.sv
// Gain correction: split multiply, then recombine and round back to Q16.16.
module pfpt_gain (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [pfpt_pkg::XW-1:0]  in_x,
    input  logic signed [pfpt_pkg::XW-1:0]  in_y,
    input  pfpt_pkg::tag_t                  in_tag,
    output logic                            out_valid,
    output logic signed [pfpt_pkg::RW-1:0]  out_x,
    output logic signed [pfpt_pkg::RW-1:0]  out_y,
    output pfpt_pkg::tag_t                  out_tag
);

    localparam int LPW = pfpt_pkg::LOW_W + pfpt_pkg::FW + 2;
    localparam int HPW = pfpt_pkg::HIGH_W + pfpt_pkg::FW + 1;
    localparam logic signed [pfpt_pkg::PW-1:0] RND = pfpt_pkg::PW'(1) <<< (pfpt_pkg::RSHIFT - 1);

    logic signed [pfpt_pkg::FW:0]   factor;
    logic signed [pfpt_pkg::PW-1:0] sum_x;
    logic signed [pfpt_pkg::PW-1:0] sum_y;

    logic                           v1_reg;
    logic signed [LPW-1:0]          xlo_reg, xlo_next;
    logic signed [HPW-1:0]          xhi_reg, xhi_next;
    logic signed [LPW-1:0]          ylo_reg, ylo_next;
    logic signed [HPW-1:0]          yhi_reg, yhi_next;
    pfpt_pkg::tag_t                 tag1_reg;

    logic                           v2_reg;
    logic signed [pfpt_pkg::RW-1:0] rx_reg, rx_next;
    logic signed [pfpt_pkg::RW-1:0] ry_reg, ry_next;
    pfpt_pkg::tag_t                 tag2_reg;

    // Stage 1: partial products against the gain (unity for pass-through)
    assign factor = $signed({1'b0, (in_tag.cmd == pfpt_pkg::CMD_PASS) ?
                             pfpt_pkg::UNITY_Q23 : pfpt_pkg::GAIN_Q23});

    always_comb begin
        xlo_next = LPW'($signed({1'b0, in_x[pfpt_pkg::LOW_W-1:0]})) * LPW'(factor);
        xhi_next = HPW'($signed(in_x[pfpt_pkg::XW-1:pfpt_pkg::LOW_W])) * HPW'(factor);
        ylo_next = LPW'($signed({1'b0, in_y[pfpt_pkg::LOW_W-1:0]})) * LPW'(factor);
        yhi_next = HPW'($signed(in_y[pfpt_pkg::XW-1:pfpt_pkg::LOW_W])) * HPW'(factor);
    end

    // Stage 2: recombine, round half up, drop guard and gain fraction bits
    always_comb begin
        sum_x   = (pfpt_pkg::PW'(xhi_reg) <<< pfpt_pkg::LOW_W) + pfpt_pkg::PW'(xlo_reg) + RND;
        sum_y   = (pfpt_pkg::PW'(yhi_reg) <<< pfpt_pkg::LOW_W) + pfpt_pkg::PW'(ylo_reg) + RND;
        rx_next = sum_x[pfpt_pkg::RSHIFT +: pfpt_pkg::RW];
        ry_next = sum_y[pfpt_pkg::RSHIFT +: pfpt_pkg::RW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xlo_reg  <= xlo_next;
            xhi_reg  <= xhi_next;
            ylo_reg  <= ylo_next;
            yhi_reg  <= yhi_next;
            tag1_reg <= in_tag;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            tag2_reg <= tag1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_x     = rx_reg;
    assign out_y     = ry_reg;
    assign out_tag   = tag2_reg;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the planar pose transform: frame changes, all commands, saturation.
module tb_top;

    localparam int ABITS          = 16;     // rotator micro-rotations, the DUT default
    localparam int GUARD_BITS     = 6;
    localparam longint GAIN_Q23   = 5094007;
    localparam int PIPE_LAT       = 19;
    localparam int SETTLE_CYCLES  = PIPE_LAT + 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [31:0] ANGLE_MASK = (32'd1 << (32 - ABITS)) - 32'd1;
    localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_MIN    = 32'h8000_0000;

    // atan(2^-i) in 32-bit fractions of a turn
    localparam logic [31:0] ATAN_TURN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D
    };

    typedef struct packed {
        pfpt_pkg::cmd_t cmd;
        logic [31:0]    x;
        logic [31:0]    y;
        logic [15:0]    heading;
    } pose_item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic        sat;
    } pose_out_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = pfpt_pkg::REG_FRAME_X;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = pfpt_pkg::CMD_TO_CHILD;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;

    // Pending stimulus and predicted results
    pose_item_t pose_q [$];
    pose_out_t  pose_expect_q [$];

    // Frame copy kept by the predictor
    longint      org_x     = 0;
    longint      org_y     = 0;
    logic [15:0] frame_rot = '0;

    int n_posed      = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_mismatch   = 0;
    int n_frames     = 0;
    int n_sat_seen   = 0;
    int n_directed   = 0;
    int cmd_count [4] = '{0, 0, 0, 0};
    int idle_cycles  = 0;

    bit tx_gaps_on  = 1'b1;
    bit rx_stalls_on = 1'b1;
    int burst_left  = 0;
    int gap_left    = 0;
    int rx_run      = 0;

    planar_frame_pose_transform u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // CORDIC rotation of (px, py) counterclockwise by a 32-bit turn fraction
    function automatic void cordic_rotate(input longint px, input longint py,
                                          input logic [31:0] ang,
                                          output longint rx, output longint ry);
        longint      x, y, z, xs, ys, a;
        logic [31:0] t, step;
        x = px;
        y = py;
        t = ang & ~ANGLE_MASK;
        // fold the left half-plane by a half turn
        if (t[31:30] == 2'b01 || t[31:30] == 2'b10) begin
            x = -x;
            y = -y;
            t = t + 32'h8000_0000;
        end
        z = longint'($signed(t));
        x = x * (64'sd1 <<< GUARD_BITS);
        y = y * (64'sd1 <<< GUARD_BITS);
        for (int i = 0; i < ABITS; i++) begin
            step = (ATAN_TURN[i] + (ANGLE_MASK >> 1) + (ANGLE_MASK & 32'd1)) & ~ANGLE_MASK;
            a  = longint'(step);
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end
        end
        // gain correction, round half up back to Q16.16
        rx = (x * GAIN_Q23 + (64'sd1 <<< (22 + GUARD_BITS))) >>> (23 + GUARD_BITS);
        ry = (y * GAIN_Q23 + (64'sd1 <<< (22 + GUARD_BITS))) >>> (23 + GUARD_BITS);
    endfunction

    function automatic logic [31:0] clamp_pos(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return POS_MAX;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return POS_MIN;
        end
        return v[31:0];
    endfunction

    // Expected result of one pose through the current frame
    function automatic pose_out_t transform_pose(input pose_item_t p);
        pose_out_t r;
        longint    x, y, rx, ry;
        logic      sat;
        x   = longint'($signed(p.x));
        y   = longint'($signed(p.y));
        rx  = x;
        ry  = y;
        sat = 1'b0;
        r.heading = p.heading;
        case (p.cmd)
            pfpt_pkg::CMD_TO_CHILD: begin
                cordic_rotate(x - org_x, y - org_y, 32'd0 - {frame_rot, 16'd0}, rx, ry);
                r.heading = p.heading - frame_rot;
            end
            pfpt_pkg::CMD_TO_PARENT: begin
                cordic_rotate(x, y, {frame_rot, 16'd0}, rx, ry);
                rx = rx + org_x;
                ry = ry + org_y;
                r.heading = p.heading + frame_rot;
            end
            pfpt_pkg::CMD_INVERT: begin
                cordic_rotate(x, y, 32'd0 - {p.heading, 16'd0}, rx, ry);
                rx = -rx;
                ry = -ry;
                r.heading = 16'd0 - p.heading;
            end
            default: ; // pass-through
        endcase
        r.x   = clamp_pos(rx, sat);
        r.y   = clamp_pos(ry, sat);
        r.sat = sat;
        return r;
    endfunction

    // Mix of full-range, moderate, small and extreme coordinates
    function automatic logic [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1:    return r;
            2, 3:    return {{8{r[23]}}, r[23:0]};
            4:       return {{16{r[15]}}, r[15:0]};
            default: begin
                case (r[1:0])
                    2'd0:    return POS_MAX;
                    2'd1:    return POS_MIN;
                    2'd2:    return 32'd0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        logic [15:0] corner [8];
        corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                   16'hFFFF, 16'h3FFF, 16'h7FFF, 16'hBFFF};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    function automatic pose_item_t rand_pose();
        pose_item_t p;
        if ($urandom_range(0, 9) == 0)
            p.cmd = pfpt_pkg::CMD_PASS;
        else
            p.cmd = pfpt_pkg::cmd_t'($urandom_range(0, 2));
        p.x       = rand_coord();
        p.y       = rand_coord();
        p.heading = rand_angle();
        return p;
    endfunction

    task automatic add_pose(input pfpt_pkg::cmd_t c, input logic [31:0] x,
                            input logic [31:0] y, input logic [15:0] h);
        pose_item_t p;
        p.cmd     = c;
        p.x       = x;
        p.y       = y;
        p.heading = h;
        pose_q.push_back(p);
        n_posed++;
    endtask

    task automatic write_reg(input pfpt_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [31:0] fx, input logic [31:0] fy,
                             input logic [15:0] th);
        write_reg(pfpt_pkg::REG_FRAME_X, fx);
        write_reg(pfpt_pkg::REG_FRAME_Y, fy);
        write_reg(pfpt_pkg::REG_FRAME_THETA, {16'd0, th});
        n_frames++;
    endtask

    // Every queued item accepted and every result returned, then let the pipe settle
    task automatic wait_drained();
        do @(negedge aclk); while (n_accepted != n_posed || pose_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Input driver: bursts of items with random gaps, or back to back while gaps are off
    always @(posedge aclk) begin : pose_driver
        pose_item_t p;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (tx_gaps_on && gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pose_q.size() != 0) begin
                p = pose_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {p.heading, p.y, p.x};
                s_tuser  <= p.cmd;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure: alternating ready and stall runs, or always ready while stalls are off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!rx_stalls_on) begin
            m_tready <= 1'b1;
        end else if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else begin
            m_tready <= !m_tready;
            rx_run   <= m_tready ? $urandom_range(0, 12) : $urandom_range(0, 6);
        end
    end

    // Monitor: track frame writes, predict accepted items, check results
    always @(posedge aclk) begin : pose_monitor
        pose_item_t p;
        pose_out_t  got, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pfpt_pkg::REG_FRAME_X:     org_x     = longint'($signed(cfg_data));
                    pfpt_pkg::REG_FRAME_Y:     org_y     = longint'($signed(cfg_data));
                    pfpt_pkg::REG_FRAME_THETA: frame_rot = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                p.cmd     = pfpt_pkg::cmd_t'(s_tuser);
                p.x       = s_tdata[31:0];
                p.y       = s_tdata[63:32];
                p.heading = s_tdata[79:64];
                want = transform_pose(p);
                pose_expect_q.push_back(want);
                cmd_count[p.cmd]++;
                if (want.sat)
                    n_sat_seen++;
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got.x       = m_tdata[31:0];
                got.y       = m_tdata[63:32];
                got.heading = m_tdata[79:64];
                got.sat     = m_tuser[0];
                if (pose_expect_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("ERROR: result with nothing expected: x=%h y=%h h=%h sat=%b",
                                 got.x, got.y, got.heading, got.sat);
                end else begin
                    want = pose_expect_q.pop_front();
                    n_checked++;
                    if (got.x !== want.x || got.y !== want.y ||
                        got.heading !== want.heading || got.sat !== want.sat) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS) begin
                            $display("ERROR: result %0d: got x=%h y=%h h=%h sat=%b",
                                     n_checked, got.x, got.y, got.heading, got.sat);
                            $display("       expected x=%h y=%h h=%h sat=%b",
                                     want.x, want.y, want.heading, want.sat);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pose_expect_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        logic [15:0] ang;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset frame: one item per command
        @(negedge aclk);
        add_pose(pfpt_pkg::CMD_TO_CHILD,  32'h0003_0000, 32'hFFFE_0000, 16'h1234);
        add_pose(pfpt_pkg::CMD_TO_PARENT, 32'h0003_0000, 32'hFFFE_0000, 16'h1234);
        add_pose(pfpt_pkg::CMD_INVERT,    32'h0003_0000, 32'hFFFE_0000, 16'h1234);
        add_pose(pfpt_pkg::CMD_PASS,      32'h0003_0000, 32'hFFFE_0000, 16'h1234);
        wait_drained();

        // extreme frame: saturation, heading wrap, quadrant boundaries, pass-through
        set_frame(POS_MAX, POS_MIN, 16'hC000);
        @(negedge aclk);
        add_pose(pfpt_pkg::CMD_TO_CHILD,  POS_MIN, POS_MAX, 16'h0000);
        add_pose(pfpt_pkg::CMD_TO_CHILD,  POS_MAX, POS_MIN, 16'hFFFF);
        add_pose(pfpt_pkg::CMD_TO_CHILD,  32'd0,   32'd0,   16'h0000);
        add_pose(pfpt_pkg::CMD_TO_PARENT, 32'd0,   32'd0,   16'h4000);
        add_pose(pfpt_pkg::CMD_TO_PARENT, POS_MAX, POS_MAX, 16'hFFFF);
        add_pose(pfpt_pkg::CMD_TO_PARENT, 32'hFFFF_FFFF, 32'd1, 16'h8000);
        add_pose(pfpt_pkg::CMD_INVERT,    POS_MIN, POS_MIN, 16'h0000);
        add_pose(pfpt_pkg::CMD_INVERT,    POS_MAX, 32'd0,   16'h8000);
        add_pose(pfpt_pkg::CMD_INVERT,    POS_MIN, POS_MAX, 16'hFFFF);
        foreach (ATAN_TURN[i]) begin
            if (i < 5) begin
                ang = (i == 0) ? 16'h4000 : (i == 1) ? 16'h3FFF : (i == 2) ? 16'h8000 :
                      (i == 3) ? 16'h7FFF : 16'hC000;
                add_pose(pfpt_pkg::CMD_INVERT, 32'h0001_0000, 32'h0002_0000, ang);
            end
        end
        add_pose(pfpt_pkg::CMD_PASS, POS_MIN, POS_MAX, 16'hFFFF);
        add_pose(pfpt_pkg::CMD_PASS, POS_MAX, POS_MIN, 16'h0000);
        n_directed = n_posed;
        wait_drained();

        // random phases over several frames; some without idling on one or both sides
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       set_frame(POS_MIN, POS_MAX, 16'h0000);
                1:       set_frame(32'd0, 32'd0, 16'h8000);
                2:       set_frame(POS_MAX, POS_MAX, 16'hFFFF);
                default: set_frame(rand_coord(), rand_coord(), 16'($urandom));
            endcase
            @(negedge aclk);
            tx_gaps_on   = (ph != 3) && (ph != 5);
            rx_stalls_on = (ph != 4) && (ph != 5);
            for (int k = 0; k < 78; k++) begin
                // hold the sender until the pipe is empty, then resume
                if (ph == 2 && k == 39) begin
                    wait_drained();
                end
                pose_q.push_back(rand_pose());
                n_posed++;
            end
            wait_drained();
        end

        n_mismatch += pose_expect_q.size();
        $display("Run covered %0d items (%0d directed) over %0d frame settings, %0d checked",
                 n_posed, n_directed, n_frames, n_checked);
        $display("Commands to-child %0d, to-parent %0d, invert %0d, pass %0d; %0d saturated",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], n_sat_seen);
        if (n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
